// ===== design/uart_pwm_command_parser_core_assert.svh =====
// Assertion macros shared by the queue and back stage modules.
`ifndef UART_PWM_COMMAND_PARSER_CORE_ASSERT_SVH
`define UART_PWM_COMMAND_PARSER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only out of reset.
`define UPCP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("upcp assertion failed");

// Checked at every edge, reset included.
`define UPCP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("upcp assertion failed");

`else

`define UPCP_ASSERT(lbl, prop)
`define UPCP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== design/upcp_pkg.sv =====
`default_nettype none

package upcp_pkg;

    localparam logic [7:0] CH_END = 8'h21;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    localparam logic [31:0] DUTY_MAX   = 32'd100;
    localparam logic [6:0]  DUTY_RESET = 7'd50;

    // keyword table: ON, OFF, Status (padded to eight positions)
    localparam logic [7:0] KW_TEXT [3][8] = '{
        '{8'h4F, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [3] = '{3'd2, 3'd3, 3'd6};

    // "PWM:"
    localparam logic [7:0] PWM_PREFIX [4] = '{8'h50, 8'h57, 8'h4D, 8'h3A};

    // pwm phase codes; 0..3 are prefix positions
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_ERR    = 3'd7;

    typedef enum logic [2:0] {
        REPLY_ON         = 3'd0,
        REPLY_OFF        = 3'd1,
        REPLY_STATUS_ON  = 3'd2,
        REPLY_STATUS_OFF = 3'd3,
        REPLY_DUTY_APPLY = 3'd4,
        REPLY_DUTY_SAVE  = 3'd5,
        REPLY_SYNTAX     = 3'd6,
        REPLY_UNKNOWN    = 3'd7
    } t_reply;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [2:0] kw_hit;     // bit0 ON, bit1 OFF, bit2 Status
        logic       pwm_prefix; // "PWM:" completed
        logic       pwm_ok;     // digits then '%'
        logic [6:0] duty;       // clamped duty
    } t_cmd;

    function automatic logic [2:0] kw_char_hit(input logic [2:0] pos, input logic [7:0] c);
        logic [2:0] hit;
        for (int k = 0; k < 3; k++) begin
            hit[k] = (pos < KW_LEN[k]) && (KW_TEXT[k][pos] == c);
        end
        return hit;
    endfunction

    function automatic logic [2:0] kw_len_hit(input logic [2:0] len);
        logic [2:0] hit;
        for (int k = 0; k < 3; k++) begin
            hit[k] = (len == KW_LEN[k]);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== design/upcp_front.sv =====
`default_nettype none

module upcp_front #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_full,
    output logic                   o_push,
    output upcp_pkg::t_cmd         o_cmd
);

    localparam int CW = $clog2(BUFFER_DEPTH);

    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_flags, n_flags;
    logic [2:0]    r_phase, n_phase;
    logic          r_ended, n_ended;
    logic [31:0]   r_acc,   n_acc;

    logic          accept;
    logic          pos_small;
    logic [2:0]    pos;
    logic [2:0]    len_hit;
    logic [2:0]    char_hit;
    logic          is_digit;
    logic [31:0]   digit;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign pos_small = ((r_count >> 3) == '0);
    assign pos       = r_count[2:0];
    assign len_hit   = pos_small ? upcp_pkg::kw_len_hit(pos) : 3'b000;
    assign char_hit  = pos_small ? upcp_pkg::kw_char_hit(pos, i_byte) : 3'b000;
    assign is_digit  = (i_byte >= upcp_pkg::CH_0) && (i_byte <= upcp_pkg::CH_9);
    assign digit     = 32'(i_byte[3:0]);

    always_comb begin
        n_count = r_count;
        n_flags = r_flags;
        n_phase = r_phase;
        n_ended = r_ended;
        n_acc   = r_acc;
        o_push  = 1'b0;
        o_cmd.kw_hit     = r_ended ? r_flags : (r_flags & len_hit);
        o_cmd.pwm_prefix = (r_phase >= upcp_pkg::PH_WAIT);
        o_cmd.pwm_ok     = (r_phase == upcp_pkg::PH_DONE);
        o_cmd.duty       = (r_acc > upcp_pkg::DUTY_MAX) ? 7'(upcp_pkg::DUTY_MAX) : r_acc[6:0];
        if (accept) begin
            if (i_byte == upcp_pkg::CH_END) begin
                o_push  = 1'b1;
                n_count = '0;
                n_flags = 3'b111;
                n_phase = upcp_pkg::PH_START;
                n_ended = 1'b0;
                n_acc   = '0;
            end else if (i_byte != upcp_pkg::CH_CR && i_byte != upcp_pkg::CH_LF &&
                         r_count < CW'(BUFFER_DEPTH - 1)) begin
                n_count = r_count + 1'b1;
                if (!r_ended) begin
                    if (i_byte == upcp_pkg::CH_NUL) begin
                        n_flags = r_flags & len_hit;
                        n_ended = 1'b1;
                    end else begin
                        n_flags = r_flags & char_hit;
                        if (r_phase < upcp_pkg::PH_WAIT) begin
                            if (pos_small && pos == r_phase &&
                                i_byte == upcp_pkg::PWM_PREFIX[r_phase[1:0]]) begin
                                n_phase = r_phase + 1'b1;
                            end
                        end else if (r_phase == upcp_pkg::PH_WAIT) begin
                            if (is_digit) begin
                                n_acc   = digit;
                                n_phase = upcp_pkg::PH_DIGITS;
                            end else begin
                                n_phase = upcp_pkg::PH_ERR;
                            end
                        end else if (r_phase == upcp_pkg::PH_DIGITS) begin
                            if (is_digit) begin
                                n_acc = (r_acc << 3) + (r_acc << 1) + digit;
                            end else if (i_byte == upcp_pkg::CH_PCT) begin
                                n_phase = upcp_pkg::PH_DONE;
                            end else begin
                                n_phase = upcp_pkg::PH_ERR;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flags <= 3'b111;
            r_phase <= upcp_pkg::PH_START;
            r_ended <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_count <= n_count;
            r_flags <= n_flags;
            r_phase <= n_phase;
            r_ended <= n_ended;
            r_acc   <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ===== design/upcp_queue.sv =====
`default_nettype none

`include "uart_pwm_command_parser_core_assert.svh"

module upcp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire upcp_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output upcp_pkg::t_cmd       o_cmd
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    upcp_pkg::t_cmd r_slot [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;
    logic           push_ok;
    logic           pop_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
        end
    end

    `UPCP_ASSERT(a_cnt_bound, r_cnt <= (AW+1)'(DEPTH))
    `UPCP_ASSERT(a_no_push_full, i_push |-> !o_full)
    `UPCP_ASSERT(a_pop_only, (pop_ok && !push_ok) |=> (r_cnt == $past(r_cnt) - 1'b1))

endmodule

`default_nettype wire

// ===== design/upcp_back.sv =====
`default_nettype none

`include "uart_pwm_command_parser_core_assert.svh"

module upcp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire upcp_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_reply_code,
    output logic [6:0]           o_duty_percent,
    output logic                 o_led_on,
    output logic [9:0]           o_compare_value
);

    logic              r_led,  n_led;
    logic [6:0]        r_duty, n_duty;
    logic              r_valid;
    upcp_pkg::t_reply  r_reply, n_reply;
    logic [6:0]        r_out_duty;
    logic              r_out_led;
    logic [9:0]        r_cmp,  n_cmp;

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        n_led   = r_led;
        n_duty  = r_duty;
        n_reply = upcp_pkg::REPLY_UNKNOWN;
        if (i_cmd.kw_hit[0]) begin
            n_led   = 1'b1;
            n_reply = upcp_pkg::REPLY_ON;
        end else if (i_cmd.kw_hit[1]) begin
            n_led   = 1'b0;
            n_reply = upcp_pkg::REPLY_OFF;
        end else if (i_cmd.kw_hit[2]) begin
            n_reply = r_led ? upcp_pkg::REPLY_STATUS_ON : upcp_pkg::REPLY_STATUS_OFF;
        end else if (i_cmd.pwm_prefix) begin
            if (i_cmd.pwm_ok) begin
                n_duty  = i_cmd.duty;
                n_reply = r_led ? upcp_pkg::REPLY_DUTY_APPLY : upcp_pkg::REPLY_DUTY_SAVE;
            end else begin
                n_reply = upcp_pkg::REPLY_SYNTAX;
            end
        end
        n_cmp = n_led ? ((10'(n_duty) << 3) + (10'(n_duty) << 1)) : 10'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led   <= 1'b0;
            r_duty  <= upcp_pkg::DUTY_RESET;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_led   <= n_led;
                r_duty  <= n_duty;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_reply    <= n_reply;
            r_out_duty <= n_duty;
            r_out_led  <= n_led;
            r_cmp      <= n_cmp;
        end
    end

    assign o_valid         = r_valid;
    assign o_reply_code    = r_reply;
    assign o_duty_percent  = r_out_duty;
    assign o_led_on        = r_out_led;
    assign o_compare_value = r_cmp;

    `UPCP_ASSERT(a_duty_range, r_duty <= 7'd100)
    `UPCP_ASSERT(a_off_zero, (r_valid && !r_out_led) |-> (r_cmp == 10'd0))
    `UPCP_ASSERT(a_no_overwrite, (r_valid && !i_ready) |-> !o_pop)

endmodule

`default_nettype wire

// ===== design/uart_pwm_command_parser_core.sv =====
// UART PWM command parser.
// s_axis carries received bytes, one per word (tdata[7:0]). Commands end in
// '!' and are ON, OFF, Status or PWM:<digits>%. CR/LF are dropped.
// m_axis carries one word per '!': reply code, duty, LED state and the
// PWM compare value (duty*10 when the LED is on, else 0).
// Throughput: one byte per cycle while the command queue is not full. A byte
// is classified in the front stage in the cycle it is taken; a '!' word
// reaches m_axis through the queue entry, then the back stage output
// register, and can wait in either while m_axis is stalled.
// A four-entry command queue sits between front and back; s_axis_tready
// drops only when that queue is full, i.e. when m_axis has been stalled
// through several pending commands. Non-'!' bytes then wait as well.
// Reset (synchronous, active low): parse state cleared, LED off, duty 50,
// queue and output register empty.
`default_nettype none

module uart_pwm_command_parser_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // [2:0] reply_code, [9:3] duty_percent,
                                            // [10] led_on, [20:11] compare_value, pad
);

    upcp_pkg::t_cmd front_cmd;
    upcp_pkg::t_cmd queue_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           queue_valid;
    logic [2:0]     reply_code;
    logic [6:0]     duty_percent;
    logic           led_on;
    logic [9:0]     compare_value;

    upcp_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    upcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    upcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (queue_valid),
        .i_cmd           (queue_cmd),
        .o_pop           (pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_reply_code    (reply_code),
        .o_duty_percent  (duty_percent),
        .o_led_on        (led_on),
        .o_compare_value (compare_value)
    );

    assign m_axis_tdata = {3'b000, compare_value, led_on, duty_percent, reply_code};

endmodule

`default_nettype wire

// ===== verif/uart_pwm_command_parser_core_checker.sv =====
`timescale 1ns / 1ps

module uart_pwm_command_parser_core_checker
    import upcp_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output logic [7:0]  o_codes_seen
);

    typedef struct packed {
        t_reply      code;
        logic [6:0]  duty;
        logic        led;
        logic [9:0]  cmp;
        logic [2:0]  pad;
    } t_led_reply;

    t_led_reply replies_due[$];
    t_led_reply got;
    t_led_reply want;

    // parser shadow
    int unsigned kept_chars;
    logic [2:0]  kw_alive;
    logic [2:0]  pwm_step;
    logic        text_done;
    logic [31:0] duty_acc;
    logic        led_is_on;
    logic [6:0]  duty_now;

    int fails = 0;
    int checked = 0;
    logic [7:0] codes_seen = '0;

    function automatic string kw_word(int k);
        case (k)
            0:       return "ON";
            1:       return "OFF";
            default: return "Status";
        endcase
    endfunction

    function automatic void restart_command();
        kept_chars = 0;
        kw_alive   = 3'b111;
        pwm_step   = PH_START;
        text_done  = 1'b0;
        duty_acc   = '0;
    endfunction

    // text ends at len: only keywords of exactly that length survive
    function automatic void cut_keywords(int unsigned len);
        string w;
        for (int k = 0; k < 3; k++) begin
            w = kw_word(k);
            if (len != w.len())
                kw_alive[k] = 1'b0;
        end
    endfunction

    function automatic void match_char(int unsigned pos, logic [7:0] c);
        string w;
        string prefix;
        logic  is_digit;
        prefix   = "PWM:";
        is_digit = (c >= CH_0) && (c <= CH_9);
        for (int k = 0; k < 3; k++) begin
            w = kw_word(k);
            if (!(pos < w.len() && w[pos] == c))
                kw_alive[k] = 1'b0;
        end
        if (pwm_step < PH_WAIT) begin
            if (pos == pwm_step && c == prefix[pwm_step])
                pwm_step = pwm_step + 3'd1;
        end else if (pwm_step == PH_WAIT) begin
            if (is_digit) begin
                duty_acc = 32'(c - CH_0);
                pwm_step = PH_DIGITS;
            end else begin
                pwm_step = PH_ERR;
            end
        end else if (pwm_step == PH_DIGITS) begin
            if (is_digit)
                duty_acc = duty_acc * 32'd10 + 32'(c - CH_0);
            else if (c == CH_PCT)
                pwm_step = PH_DONE;
            else
                pwm_step = PH_ERR;
        end
    endfunction

    function automatic void take_rx_byte(logic [7:0] c);
        t_led_reply r;
        int unsigned pos;
        if (c == CH_END) begin
            if (!text_done)
                cut_keywords(kept_chars);
            if (kw_alive[0]) begin
                led_is_on = 1'b1;
                r.code = REPLY_ON;
            end else if (kw_alive[1]) begin
                led_is_on = 1'b0;
                r.code = REPLY_OFF;
            end else if (kw_alive[2]) begin
                r.code = led_is_on ? REPLY_STATUS_ON : REPLY_STATUS_OFF;
            end else if (pwm_step >= PH_WAIT) begin
                if (pwm_step == PH_DONE) begin
                    duty_now = (duty_acc > DUTY_MAX) ? DUTY_MAX[6:0] : duty_acc[6:0];
                    r.code = led_is_on ? REPLY_DUTY_APPLY : REPLY_DUTY_SAVE;
                end else begin
                    r.code = REPLY_SYNTAX;
                end
            end else begin
                r.code = REPLY_UNKNOWN;
            end
            r.duty = duty_now;
            r.led  = led_is_on;
            r.cmp  = led_is_on ? 10'(duty_now) * 10'd10 : 10'd0;
            r.pad  = '0;
            replies_due.push_back(r);
            restart_command();
        end else if (c != CH_CR && c != CH_LF && kept_chars < BUFFER_DEPTH - 1) begin
            pos = kept_chars;
            kept_chars++;
            if (!text_done) begin
                if (c == CH_NUL) begin
                    cut_keywords(pos);
                    text_done = 1'b1;
                end else begin
                    match_char(pos, c);
                end
            end
        end
    endfunction

    function automatic void compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_command();
            led_is_on = 1'b0;
            duty_now  = DUTY_RESET;
            replies_due.delete();
        end else begin
            // results first: a word out can never belong to a byte taken at this edge
            if (i_m_tvalid && i_m_tready) begin
                got.code = t_reply'(i_m_tdata[2:0]);
                got.duty = i_m_tdata[9:3];
                got.led  = i_m_tdata[10];
                got.cmp  = i_m_tdata[20:11];
                got.pad  = i_m_tdata[23:21];
                if (replies_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected reply word, expected none, actual %h",
                             $time, i_m_tdata);
                end else begin
                    want = replies_due.pop_front();
                    compare_field("reply_code", want.code, got.code);
                    compare_field("duty_percent", want.duty, got.duty);
                    compare_field("led_on", want.led, got.led);
                    compare_field("compare_value", want.cmp, got.cmp);
                    compare_field("pad", want.pad, got.pad);
                    codes_seen[want.code] = 1'b1;
                end
                checked++;
            end
            if (i_s_tvalid && i_s_tready)
                take_rx_byte(i_s_tdata);
        end
        o_pending    <= replies_due.size();
        o_errors     <= fails;
        o_checked    <= checked;
        o_codes_seen <= codes_seen;
    end

endmodule

// ===== verif/uart_pwm_command_parser_core_tb.sv =====
`timescale 1ns / 1ps

module uart_pwm_command_parser_core_tb;
    import upcp_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_BYTES = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [2:0] code, [9:3] duty, [10] led, [20:11] compare

    int          errors;
    int          pending;
    int          checked;
    logic [7:0]  codes_seen;

    int unsigned cycles     = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    logic [7:0]  cmd_bytes[$];

    uart_pwm_command_parser_core #(
        .BUFFER_DEPTH (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    uart_pwm_command_parser_core_checker #(
        .BUFFER_DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_codes_seen (codes_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // reply side: always ready, random, or mostly stalled, in stretches
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(1, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_cmd();
        while (cmd_bytes.size() > 0)
            send_byte(cmd_bytes.pop_front());
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            cmd_bytes.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_cmd();
    endtask

    task automatic wait_replies();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        return (c == CH_END) ? 8'h78 : c;
    endfunction

    task automatic build_random_cmd();
        int kind;
        int sel;
        int n;
        cmd_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            push_text("ON");
        end else if (kind < 27) begin
            push_text("OFF");
        end else if (kind < 38) begin
            push_text("Status");
        end else if (kind < 88) begin
            push_text("PWM:");
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                push_text($sformatf("%0d", $urandom_range(0, 120)));
            end else if (sel < 8) begin
                push_text($sformatf("%0d", $urandom));
            end else begin
                n = $urandom_range(0, 12);
                repeat (n) cmd_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 9) != 0)
                cmd_bytes.push_back(CH_PCT);
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) cmd_bytes.push_back(junk_char());
            end
        end else begin
            n = $urandom_range(0, 12);
            repeat (n) cmd_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // broken variants of the well-formed text
        if (kind < 88 && $urandom_range(0, 5) == 0) begin
            sel = $urandom_range(0, cmd_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0:       cmd_bytes[sel] = 8'($urandom_range(0, 255));
                1:       cmd_bytes.insert(sel, CH_NUL);
                default: cmd_bytes.delete(sel);
            endcase
        end
        if ($urandom_range(0, 6) == 0)
            cmd_bytes.insert($urandom_range(0, cmd_bytes.size()),
                             $urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 24) == 0)
            while (cmd_bytes.size() < 70) cmd_bytes.push_back(junk_char());
        if ($urandom_range(0, 19) != 0)
            cmd_bytes.push_back(CH_END);
    endtask

    initial begin
        int start_bytes;
        bit drained_mid;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("!");
        send_text("Status!");
        send_text("PWM:75%!");
        send_text("ON!");
        send_text("Status!");
        send_text("PWM:0%!");
        send_text("PWM:100%!");
        send_text("PWM:4294967295%!");
        send_text("PWM:4294967296%!");
        send_text("PWM:007%trail!");
        send_text("PWM:%!");
        send_text("PWM:12!");
        send_text("PWM:1x%!");
        send_text("PWM5%!");
        send_text("O\r\nN\r\n!");
        send_text("OF!");
        send_text("OFF!");
        send_text("ONX!");
        push_text("O");
        cmd_bytes.push_back(CH_NUL);
        send_text("N!");
        push_text("ON");
        cmd_bytes.push_back(CH_NUL);
        cmd_bytes.push_back(8'hFF);
        cmd_bytes.push_back(8'h80);
        send_text("!");
        push_text("PWM:3");
        cmd_bytes.push_back(CH_NUL);
        send_text("%!");
        push_text("PWM:9%");
        repeat (70) cmd_bytes.push_back(8'h7A);
        send_text("!");
        repeat (62) cmd_bytes.push_back(8'h61);
        send_text("ON!");
        wait_replies();

        start_bytes = bytes_sent;
        drained_mid = 1'b0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            build_random_cmd();
            send_cmd();
            if (!drained_mid && bytes_sent - start_bytes > RANDOM_BYTES / 2) begin
                drained_mid = 1'b1;
                wait_replies();
            end
        end
        cmd_bytes.push_back(CH_END);
        send_cmd();
        wait_replies();
        repeat (10) @(posedge i_clk);

        $display("Drove %0d received bytes, %0d reply words checked", bytes_sent, checked);
        $display("Reply codes seen (bit per code): %b", codes_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
